### rtl/xed_pkg.sv
package xed_pkg;

  localparam int ByteW    = 8;
  localparam int MaxOut   = 6;
  localparam int MaxHeld  = 5;

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t [MaxHeld-1:0] held_t;
  typedef logic [2:0] cnt_t;

  localparam byte_t ChAmp   = 8'h26;
  localparam byte_t ChA     = 8'h61;
  localparam byte_t ChM     = 8'h6D;
  localparam byte_t ChP     = 8'h70;
  localparam byte_t ChSemi  = 8'h3B;
  localparam byte_t ChL     = 8'h6C;
  localparam byte_t ChT     = 8'h74;
  localparam byte_t ChG     = 8'h67;
  localparam byte_t ChQ     = 8'h71;
  localparam byte_t ChU     = 8'h75;
  localparam byte_t ChO     = 8'h6F;
  localparam byte_t ChHash  = 8'h23;
  localparam byte_t ChX     = 8'h78;
  localparam byte_t ChUpD   = 8'h44;
  localparam byte_t ChUpA   = 8'h41;
  localparam byte_t ChLt    = 8'h3C;
  localparam byte_t ChGt    = 8'h3E;
  localparam byte_t ChQuot  = 8'h22;
  localparam byte_t ChCr    = 8'h0D;
  localparam byte_t ChLf    = 8'h0A;

  typedef enum logic [4:0] {
    PfxNone = 5'd0,
    PfxAmp  = 5'd1,
    PfxA    = 5'd2,
    PfxAm   = 5'd3,
    PfxAmpW = 5'd4,
    PfxL    = 5'd5,
    PfxLt   = 5'd6,
    PfxG    = 5'd7,
    PfxGt   = 5'd8,
    PfxQ    = 5'd9,
    PfxQu   = 5'd10,
    PfxQuo  = 5'd11,
    PfxQuot = 5'd12,
    PfxHash = 5'd13,
    PfxHx   = 5'd14,
    PfxHxD  = 5'd15,
    PfxHxA  = 5'd16
  } prefix_t;

  function automatic cnt_t held_len(prefix_t s);
    cnt_t n;
    unique case (s)
      PfxAmp:                                 n = 3'd1;
      PfxA, PfxL, PfxG, PfxQ, PfxHash:        n = 3'd2;
      PfxAm, PfxLt, PfxGt, PfxQu, PfxHx:      n = 3'd3;
      PfxAmpW, PfxQuo, PfxHxD, PfxHxA:        n = 3'd4;
      PfxQuot:                                n = 3'd5;
      default:                                n = 3'd0;
    endcase
    return n;
  endfunction

  // element 0 is the first byte held
  function automatic held_t held_text(prefix_t s);
    held_t t;
    t = '{default: ChAmp};
    unique case (s)
      PfxA:    t[1] = ChA;
      PfxAm:   begin t[1] = ChA; t[2] = ChM; end
      PfxAmpW: begin t[1] = ChA; t[2] = ChM; t[3] = ChP; end
      PfxL:    t[1] = ChL;
      PfxLt:   begin t[1] = ChL; t[2] = ChT; end
      PfxG:    t[1] = ChG;
      PfxGt:   begin t[1] = ChG; t[2] = ChT; end
      PfxQ:    t[1] = ChQ;
      PfxQu:   begin t[1] = ChQ; t[2] = ChU; end
      PfxQuo:  begin t[1] = ChQ; t[2] = ChU; t[3] = ChO; end
      PfxQuot: begin t[1] = ChQ; t[2] = ChU; t[3] = ChO; t[4] = ChT; end
      PfxHash: t[1] = ChHash;
      PfxHx:   begin t[1] = ChHash; t[2] = ChX; end
      PfxHxD:  begin t[1] = ChHash; t[2] = ChX; t[3] = ChUpD; end
      PfxHxA:  begin t[1] = ChHash; t[2] = ChX; t[3] = ChUpA; end
      default: ;
    endcase
    return t;
  endfunction

endpackage

### rtl/xed_in_if.sv
interface xed_in_if;
  logic                     valid;
  logic                     ready;
  logic [xed_pkg::ByteW-1:0] text_byte;
  logic                     end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

### rtl/xed_out_if.sv
interface xed_out_if;
  logic                     valid;
  logic                     ready;
  logic [xed_pkg::ByteW-1:0] plain_byte;
  logic                     run_last;
  logic                     text_done;

  modport source(output valid, output plain_byte, output run_last, output text_done,
                 input ready);
  modport sink(input valid, input plain_byte, input run_last, input text_done,
               output ready);
endinterface

### rtl/xml_entity_decoder.sv
// XML entity decoder.
// text_in carries one escaped byte per transaction with end_of_text on the
// last byte of a text. plain_out carries decoded bytes; run_last marks the
// last byte caused by one input transaction, text_done the last byte of a text.
// Each accepted byte yields 0 to 6 output bytes, held in a result register
// that shifts out one byte per cycle while plain_out.ready is high. The first
// of them is valid the cycle after the input transaction.
// Throughput: one input byte per cycle while plain_out.ready is high and each
// byte yields at most one output; a byte that yields more (a broken prefix,
// the byte itself and, at end of text, a prefix still held) stalls the input.
// text_in.ready is high when the result register is empty or is sending its
// last byte in this cycle, so a stalled receiver holds the input off after
// at most one pending transaction.
// Reset: synchronous, clears the held entity prefix and empties the result
// register.
module xml_entity_decoder (
  input  logic            clk,
  input  logic            rst,
  xed_in_if.sink          text_in,
  xed_out_if.source       plain_out
);

  xed_pkg::prefix_t prefix;
  xed_pkg::prefix_t prefix_next;
  xed_pkg::byte_t   buf_q [xed_pkg::MaxOut];
  xed_pkg::byte_t   buf_next [xed_pkg::MaxOut];
  xed_pkg::cnt_t    cnt;
  xed_pkg::cnt_t    cnt_next;
  logic             done_q;

  logic             brk;
  logic             dec_v;
  xed_pkg::byte_t   dec_b;
  xed_pkg::prefix_t s_adv;
  xed_pkg::prefix_t s_mid;
  logic             byte_v;
  logic             flush_end;

  logic in_fire;
  logic out_fire;

  assign out_fire      = plain_out.valid && plain_out.ready;
  assign text_in.ready = (cnt == 3'd0) || (cnt == 3'd1 && plain_out.ready);
  assign in_fire       = text_in.valid && text_in.ready;

  // advance the held prefix by one byte
  always_comb begin
    brk   = 1'b0;
    dec_v = 1'b0;
    dec_b = '0;
    s_adv = xed_pkg::PfxNone;
    unique case (prefix)
      xed_pkg::PfxNone: ;
      xed_pkg::PfxAmp: begin
        priority if (text_in.text_byte == xed_pkg::ChA)    s_adv = xed_pkg::PfxA;
        else if (text_in.text_byte == xed_pkg::ChL)        s_adv = xed_pkg::PfxL;
        else if (text_in.text_byte == xed_pkg::ChG)        s_adv = xed_pkg::PfxG;
        else if (text_in.text_byte == xed_pkg::ChQ)        s_adv = xed_pkg::PfxQ;
        else if (text_in.text_byte == xed_pkg::ChHash)     s_adv = xed_pkg::PfxHash;
        else                                               brk = 1'b1;
      end
      xed_pkg::PfxA: begin
        if (text_in.text_byte == xed_pkg::ChM) s_adv = xed_pkg::PfxAm;
        else brk = 1'b1;
      end
      xed_pkg::PfxAm: begin
        if (text_in.text_byte == xed_pkg::ChP) s_adv = xed_pkg::PfxAmpW;
        else brk = 1'b1;
      end
      xed_pkg::PfxL: begin
        if (text_in.text_byte == xed_pkg::ChT) s_adv = xed_pkg::PfxLt;
        else brk = 1'b1;
      end
      xed_pkg::PfxG: begin
        if (text_in.text_byte == xed_pkg::ChT) s_adv = xed_pkg::PfxGt;
        else brk = 1'b1;
      end
      xed_pkg::PfxQ: begin
        if (text_in.text_byte == xed_pkg::ChU) s_adv = xed_pkg::PfxQu;
        else brk = 1'b1;
      end
      xed_pkg::PfxQu: begin
        if (text_in.text_byte == xed_pkg::ChO) s_adv = xed_pkg::PfxQuo;
        else brk = 1'b1;
      end
      xed_pkg::PfxQuo: begin
        if (text_in.text_byte == xed_pkg::ChT) s_adv = xed_pkg::PfxQuot;
        else brk = 1'b1;
      end
      xed_pkg::PfxHash: begin
        if (text_in.text_byte == xed_pkg::ChX) s_adv = xed_pkg::PfxHx;
        else brk = 1'b1;
      end
      xed_pkg::PfxHx: begin
        priority if (text_in.text_byte == xed_pkg::ChUpD) s_adv = xed_pkg::PfxHxD;
        else if (text_in.text_byte == xed_pkg::ChUpA)     s_adv = xed_pkg::PfxHxA;
        else                                              brk = 1'b1;
      end
      xed_pkg::PfxAmpW, xed_pkg::PfxLt, xed_pkg::PfxGt, xed_pkg::PfxQuot,
      xed_pkg::PfxHxD, xed_pkg::PfxHxA: begin
        if (text_in.text_byte == xed_pkg::ChSemi) begin
          dec_v = 1'b1;
          unique case (prefix)
            xed_pkg::PfxAmpW: dec_b = xed_pkg::ChAmp;
            xed_pkg::PfxLt:   dec_b = xed_pkg::ChLt;
            xed_pkg::PfxGt:   dec_b = xed_pkg::ChGt;
            xed_pkg::PfxQuot: dec_b = xed_pkg::ChQuot;
            xed_pkg::PfxHxD:  dec_b = xed_pkg::ChCr;
            default:          dec_b = xed_pkg::ChLf;
          endcase
        end else begin
          brk = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next prefix
  always_comb begin
    byte_v = 1'b0;
    if (prefix != xed_pkg::PfxNone && !brk) begin
      s_mid = s_adv;
    end else if (text_in.text_byte == xed_pkg::ChAmp) begin
      s_mid = xed_pkg::PfxAmp;
    end else begin
      s_mid  = xed_pkg::PfxNone;
      byte_v = 1'b1;
    end
    flush_end   = text_in.end_of_text && (s_mid != xed_pkg::PfxNone);
    prefix_next = flush_end ? xed_pkg::PfxNone : s_mid;
  end

  // result bytes: flushed prefix or decoded char, new byte, prefix flushed at end
  always_comb begin
    xed_pkg::held_t a_txt;
    xed_pkg::held_t c_txt;
    logic [2:0]     la;
    logic [2:0]     lc;
    logic [3:0]     lab;
    logic [3:0]     n;
    logic [3:0]     kk;
    logic [3:0]     ci;
    a_txt = xed_pkg::held_text(prefix);
    c_txt = xed_pkg::held_text(s_mid);
    if (brk) begin
      la = xed_pkg::held_len(prefix);
    end else begin
      la       = {2'b00, dec_v};
      a_txt[0] = dec_b;
    end
    lc  = flush_end ? xed_pkg::held_len(s_mid) : 3'd0;
    lab = {1'b0, la} + {3'b000, byte_v};
    n   = lab + {1'b0, lc};
    for (int k = 0; k < xed_pkg::MaxOut; k++) begin
      kk = 4'(k);
      ci = kk - lab;
      if (kk < {1'b0, la}) begin
        buf_next[k] = a_txt[kk[2:0]];
      end else if (kk < lab) begin
        buf_next[k] = text_in.text_byte;
      end else if (kk < n) begin
        buf_next[k] = c_txt[ci[2:0]];
      end else begin
        buf_next[k] = '0;
      end
    end
    cnt_next = n[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= xed_pkg::PfxNone;
      cnt    <= '0;
    end else if (in_fire) begin
      prefix <= prefix_next;
      cnt    <= cnt_next;
    end else if (out_fire) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_q  <= buf_next;
      done_q <= text_in.end_of_text;
    end else if (out_fire) begin
      for (int i = 0; i < xed_pkg::MaxOut - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  assign plain_out.valid      = (cnt != 3'd0);
  assign plain_out.plain_byte = buf_q[0];
  assign plain_out.run_last   = (cnt == 3'd1);
  assign plain_out.text_done  = (cnt == 3'd1) && done_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(xed_pkg::MaxOut))
    else $error("result count out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && text_in.end_of_text |=> prefix == xed_pkg::PfxNone)
    else $error("prefix held past end of text");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    plain_out.valid && !plain_out.ready |=> cnt == $past(cnt))
    else $error("result count changed while stalled");

  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    text_in.ready |-> cnt <= 3'd1)
    else $error("input ready with results pending");
`endif

endmodule
